// ===== hdl/hssc_pkg.sv =====
`timescale 1ns / 1ps

package hssc_pkg;

  localparam logic [4:0]  DUTY_MAX   = 5'd25;
  localparam logic [14:0] AGE_MAX    = 15'h7FFF;
  localparam logic [7:0]  CNT_MAX    = 8'hFF;
  localparam logic [2:0]  SEQ_LAST   = 3'd5;
  localparam logic [3:0]  SEQ_LEN    = 4'd6;

  // x / 100 == (x * PCT_RECIP) >> PCT_SHIFT for every x below 2**21
  localparam int          PCT_SHIFT  = 28;
  localparam logic [21:0] PCT_RECIP  = 22'd2684355;

  // configuration register indexes
  localparam logic [2:0] CFG_REVERSE_DIR    = 3'd0;
  localparam logic [2:0] CFG_SECTOR_OFFSET  = 3'd1;
  localparam logic [2:0] CFG_KICK_DUTY      = 3'd2;
  localparam logic [2:0] CFG_RUN_DUTY       = 3'd3;
  localparam logic [2:0] CFG_PWM_PERIOD     = 3'd4;
  localparam logic [2:0] CFG_KICK_INTERVAL  = 3'd5;
  localparam logic [2:0] CFG_KICK_SYNC_MIN  = 3'd6;
  localparam logic [2:0] CFG_KICK_MAX_STEPS = 3'd7;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_PWM = 2'd1,
    MODE_LOW = 2'd2
  } phase_mode_t;

  typedef struct packed {
    phase_mode_t u;
    phase_mode_t v;
    phase_mode_t w;
  } phase_set_t;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] hall_code;
  } in_item_t;

  typedef struct packed {
    logic        running;
    logic        kicking;
    logic        fault;
    logic [2:0]  step_index;
    logic [1:0]  mode_u;
    logic [1:0]  mode_v;
    logic [1:0]  mode_w;
    logic [16:0] compare_u;
    logic [16:0] compare_v;
    logic [16:0] compare_w;
    logic [14:0] edge_age;
    logic [15:0] edge_total;
  } out_item_t;

  typedef struct packed {
    logic        reverse_dir;
    logic [2:0]  sector_offset;
    logic [4:0]  kick_duty;
    logic [4:0]  run_duty;
    logic [15:0] pwm_period;
    logic [15:0] kick_interval;
    logic [7:0]  kick_sync_min;
    logic [7:0]  kick_max_steps;
  } cfg_t;

  // hall code at a position of the commutation sequence
  function automatic logic [2:0] seq_code(input logic rev, input logic [2:0] pos);
    logic [2:0] c;
    c = 3'd5;
    case (pos)
      3'd0:    c = 3'd5;
      3'd1:    c = rev ? 3'd1 : 3'd4;
      3'd2:    c = rev ? 3'd3 : 3'd6;
      3'd3:    c = 3'd2;
      3'd4:    c = rev ? 3'd6 : 3'd3;
      3'd5:    c = rev ? 3'd4 : 3'd1;
      default: c = 3'd5;
    endcase
    return c;
  endfunction

  // position of a hall code in the sequence; invalid codes give 0
  function automatic logic [2:0] seq_pos(input logic rev, input logic [2:0] code);
    logic [2:0] p;
    p = 3'd0;
    case (code)
      3'd5:    p = 3'd0;
      3'd1:    p = rev ? 3'd1 : 3'd5;
      3'd3:    p = rev ? 3'd2 : 3'd4;
      3'd2:    p = 3'd3;
      3'd6:    p = rev ? 3'd4 : 3'd2;
      3'd4:    p = rev ? 3'd5 : 3'd1;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

  // rotate a raw hall code along the sequence
  function automatic logic [2:0] map_code(input logic rev, input logic [2:0] offset,
                                          input logic [2:0] raw);
    logic [3:0] s;
    s = {1'b0, seq_pos(rev, raw)} + {1'b0, offset};
    if (s >= SEQ_LEN) begin
      s = s - SEQ_LEN;
    end
    if (raw == 3'd0 || raw == 3'd7) begin
      return raw;
    end
    return seq_code(rev, s[2:0]);
  endfunction

  // forward drive pattern per hall code
  function automatic phase_set_t drive_modes(input logic [2:0] code);
    phase_set_t d;
    d = '{MODE_OFF, MODE_OFF, MODE_OFF};
    case (code)
      3'd1:    d = '{MODE_PWM, MODE_OFF, MODE_LOW};
      3'd2:    d = '{MODE_LOW, MODE_PWM, MODE_OFF};
      3'd3:    d = '{MODE_OFF, MODE_PWM, MODE_LOW};
      3'd4:    d = '{MODE_OFF, MODE_LOW, MODE_PWM};
      3'd5:    d = '{MODE_PWM, MODE_LOW, MODE_OFF};
      3'd6:    d = '{MODE_LOW, MODE_OFF, MODE_PWM};
      default: d = '{MODE_OFF, MODE_OFF, MODE_OFF};
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/hssc_pulse.sv =====
`timescale 1ns / 1ps

module hssc_pulse
  import hssc_pkg::*;
(
  input  logic        clk,
  input  cfg_t        cfg,
  output logic [15:0] kick_pulse,
  output logic [15:0] run_pulse
);

  logic [20:0] kick_prod_r;
  logic [20:0] run_prod_r;
  logic [43:0] kick_frac_r;
  logic [43:0] run_frac_r;

  // period * duty, then divide by 100 through the reciprocal
  always_ff @(posedge clk) begin
    kick_prod_r <= 21'(cfg.pwm_period) * 21'(cfg.kick_duty);
    run_prod_r  <= 21'(cfg.pwm_period) * 21'(cfg.run_duty);
    kick_frac_r <= 44'(kick_prod_r) * 44'(PCT_RECIP);
    run_frac_r  <= 44'(run_prod_r) * 44'(PCT_RECIP);
  end

  assign kick_pulse = kick_frac_r[PCT_SHIFT +: 16];
  assign run_pulse  = run_frac_r[PCT_SHIFT +: 16];

endmodule

// ===== hdl/hssc_core.sv =====
`timescale 1ns / 1ps

module hssc_core
  import hssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  in_item_t    item,
  input  cfg_t        cfg,
  input  logic [15:0] kick_pulse,
  input  logic [15:0] run_pulse,
  output out_item_t   res
);

  logic        enabled_r, enabled_nxt;
  logic        kick_r, kick_nxt;
  logic        fault_r, fault_nxt;
  logic [2:0]  prev_hall_r, prev_hall_nxt;
  logic [2:0]  kick_pos_r, kick_pos_nxt;
  logic [15:0] kick_div_r, kick_div_nxt;
  logic [7:0]  step_cnt_r, step_cnt_nxt;
  logic [7:0]  kedge_cnt_r, kedge_cnt_nxt;
  logic [14:0] age_r, age_nxt;
  logic [15:0] edge_cnt_r, edge_cnt_nxt;
  logic [2:0]  last_step_r, last_step_nxt;
  phase_set_t  modes_r, modes_nxt;
  logic [16:0] cmp_u_r, cmp_u_nxt;
  logic [16:0] cmp_v_r, cmp_v_nxt;
  logic [16:0] cmp_w_r, cmp_w_nxt;

  logic        hall_moved;
  logic [15:0] div_inc;
  logic [2:0]  pos_inc;
  logic        do_comm;
  logic [2:0]  comm_code;
  logic [15:0] comm_pulse;
  logic [16:0] pwm_cmp;
  logic [16:0] low_cmp;
  phase_set_t  drv;

  function automatic phase_mode_t swap_mode(input phase_mode_t m, input logic rev);
    phase_mode_t r;
    r = m;
    if (rev && m == MODE_PWM) begin
      r = MODE_LOW;
    end else if (rev && m == MODE_LOW) begin
      r = MODE_PWM;
    end
    return r;
  endfunction

  function automatic logic [16:0] mode_cmp(input phase_mode_t m, input logic [16:0] pwm,
                                           input logic [16:0] low);
    logic [16:0] c;
    c = '0;
    case (m)
      MODE_PWM: c = pwm;
      MODE_LOW: c = low;
      default:  c = '0;
    endcase
    return c;
  endfunction

  always_comb begin
    enabled_nxt   = enabled_r;
    kick_nxt      = kick_r;
    fault_nxt     = fault_r;
    prev_hall_nxt = prev_hall_r;
    kick_pos_nxt  = kick_pos_r;
    kick_div_nxt  = kick_div_r;
    step_cnt_nxt  = step_cnt_r;
    kedge_cnt_nxt = kedge_cnt_r;
    age_nxt       = age_r;
    edge_cnt_nxt  = edge_cnt_r;
    last_step_nxt = last_step_r;
    modes_nxt     = modes_r;
    cmp_u_nxt     = cmp_u_r;
    cmp_v_nxt     = cmp_v_r;
    cmp_w_nxt     = cmp_w_r;
    do_comm       = 1'b0;
    comm_code     = 3'd0;
    comm_pulse    = kick_pulse;

    hall_moved = item.hall_code != prev_hall_r;
    div_inc    = kick_div_r + 16'd1;
    pos_inc    = (kick_pos_r == SEQ_LAST) ? 3'd0 : kick_pos_r + 3'd1;

    case (item.func)
      FUNC_START: begin
        enabled_nxt   = 1'b1;
        fault_nxt     = 1'b0;
        edge_cnt_nxt  = '0;
        kick_nxt      = 1'b1;
        kick_pos_nxt  = seq_pos(cfg.reverse_dir, item.hall_code);
        kick_div_nxt  = '0;
        step_cnt_nxt  = '0;
        kedge_cnt_nxt = '0;
        prev_hall_nxt = item.hall_code;
        do_comm       = 1'b1;
        comm_code     = map_code(cfg.reverse_dir, cfg.sector_offset, item.hall_code);
      end
      FUNC_STOP: begin
        enabled_nxt = 1'b0;
        kick_nxt    = 1'b0;
        modes_nxt   = '{MODE_OFF, MODE_OFF, MODE_OFF};
        cmp_u_nxt   = '0;
        cmp_v_nxt   = '0;
        cmp_w_nxt   = '0;
      end
      FUNC_TICK: begin
        if (enabled_r) begin
          if (hall_moved) begin
            edge_cnt_nxt  = edge_cnt_r + 16'd1;
            if (kick_r && kedge_cnt_r != CNT_MAX) begin
              kedge_cnt_nxt = kedge_cnt_r + 8'd1;
            end
            prev_hall_nxt = item.hall_code;
            age_nxt       = '0;
          end else if (age_r != AGE_MAX) begin
            age_nxt = age_r + 15'd1;
          end

          if (kick_r) begin
            kick_div_nxt = div_inc;
            if (div_inc >= cfg.kick_interval) begin
              // forced open-loop step
              kick_div_nxt = '0;
              kick_pos_nxt = pos_inc;
              if (step_cnt_r != CNT_MAX) begin
                step_cnt_nxt = step_cnt_r + 8'd1;
              end
              do_comm   = 1'b1;
              comm_code = map_code(cfg.reverse_dir, cfg.sector_offset,
                                   seq_code(cfg.reverse_dir, pos_inc));
              if (kedge_cnt_nxt >= cfg.kick_sync_min ||
                  step_cnt_nxt >= cfg.kick_max_steps) begin
                kick_nxt = 1'b0;
              end
            end
          end else if (hall_moved) begin
            do_comm    = 1'b1;
            comm_code  = map_code(cfg.reverse_dir, cfg.sector_offset, item.hall_code);
            comm_pulse = run_pulse;
          end
        end
      end
      default: begin
      end
    endcase

    pwm_cmp = {1'b0, comm_pulse};
    low_cmp = {1'b0, cfg.pwm_period} + 17'd1;
    drv     = drive_modes(comm_code);
    drv.u   = swap_mode(drv.u, cfg.reverse_dir);
    drv.v   = swap_mode(drv.v, cfg.reverse_dir);
    drv.w   = swap_mode(drv.w, cfg.reverse_dir);

    if (do_comm) begin
      if (comm_code == 3'd0 || comm_code == 3'd7) begin
        // invalid hall: flag it, keep the drive
        fault_nxt = 1'b1;
      end else begin
        fault_nxt     = 1'b0;
        modes_nxt     = drv;
        cmp_u_nxt     = mode_cmp(drv.u, pwm_cmp, low_cmp);
        cmp_v_nxt     = mode_cmp(drv.v, pwm_cmp, low_cmp);
        cmp_w_nxt     = mode_cmp(drv.w, pwm_cmp, low_cmp);
        last_step_nxt = seq_pos(cfg.reverse_dir, comm_code);
      end
    end
  end

  always_comb begin
    res.running    = enabled_nxt;
    res.kicking    = kick_nxt;
    res.fault      = fault_nxt;
    res.step_index = last_step_nxt;
    res.mode_u     = modes_nxt.u;
    res.mode_v     = modes_nxt.v;
    res.mode_w     = modes_nxt.w;
    res.compare_u  = cmp_u_nxt;
    res.compare_v  = cmp_v_nxt;
    res.compare_w  = cmp_w_nxt;
    res.edge_age   = age_nxt;
    res.edge_total = edge_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b0;
      kick_r      <= 1'b0;
      fault_r     <= 1'b0;
      prev_hall_r <= '0;
      kick_pos_r  <= '0;
      kick_div_r  <= '0;
      step_cnt_r  <= '0;
      kedge_cnt_r <= '0;
      age_r       <= '0;
      edge_cnt_r  <= '0;
      last_step_r <= '0;
      modes_r     <= '{MODE_OFF, MODE_OFF, MODE_OFF};
      cmp_u_r     <= '0;
      cmp_v_r     <= '0;
      cmp_w_r     <= '0;
    end else if (step_en) begin
      enabled_r   <= enabled_nxt;
      kick_r      <= kick_nxt;
      fault_r     <= fault_nxt;
      prev_hall_r <= prev_hall_nxt;
      kick_pos_r  <= kick_pos_nxt;
      kick_div_r  <= kick_div_nxt;
      step_cnt_r  <= step_cnt_nxt;
      kedge_cnt_r <= kedge_cnt_nxt;
      age_r       <= age_nxt;
      edge_cnt_r  <= edge_cnt_nxt;
      last_step_r <= last_step_nxt;
      modes_r     <= modes_nxt;
      cmp_u_r     <= cmp_u_nxt;
      cmp_v_r     <= cmp_v_nxt;
      cmp_w_r     <= cmp_w_nxt;
    end
  end

endmodule

// ===== hdl/hall_six_step_commutator.sv =====
`timescale 1ns / 1ps

// Hall six-step commutator with open-loop kick. Each input beat (tick, start
// or stop with the raw hall code) yields exactly one result beat holding the
// drive state after that beat. Throughput is one beat per clock unless the
// output stalls or a write settles. A beat passes the input register, then
// the commutation logic into the result register. The PWM compare values
// come from a two-stage multiply pipeline (period * duty, then divide by 100
// through a reciprocal), so after each configuration write in_ready stays
// low while it settles. Write configuration only while no beat is in flight.

module hall_six_step_commutator
  import hssc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [1:0] CFG_SETTLE = 2'd2;

  cfg_t        cfg_r, cfg_nxt;
  logic [1:0]  settle_r, settle_nxt;
  logic        in_vld_r;
  in_item_t    in_r;
  logic        out_vld_r;
  out_item_t   out_r;
  logic        advance;
  logic        cfg_we;
  logic [15:0] kick_pulse;
  logic [15:0] run_pulse;
  out_item_t   res;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = (settle_r == 2'd0) && (!in_vld_r || advance);
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    cfg_nxt    = cfg_r;
    settle_nxt = (settle_r != 2'd0) ? settle_r - 2'd1 : settle_r;
    if (cfg_we) begin
      settle_nxt = CFG_SETTLE;
      case (cfg_index)
        CFG_REVERSE_DIR:   cfg_nxt.reverse_dir = cfg_data[0];
        CFG_SECTOR_OFFSET: cfg_nxt.sector_offset = (cfg_data[2:0] >= 3'd6) ?
                                                   cfg_data[2:0] - 3'd6 : cfg_data[2:0];
        CFG_KICK_DUTY:     cfg_nxt.kick_duty = (cfg_data[4:0] > DUTY_MAX) ?
                                               DUTY_MAX : cfg_data[4:0];
        CFG_RUN_DUTY:      cfg_nxt.run_duty = (cfg_data[4:0] > DUTY_MAX) ?
                                              DUTY_MAX : cfg_data[4:0];
        CFG_PWM_PERIOD:    cfg_nxt.pwm_period = cfg_data;
        CFG_KICK_INTERVAL: cfg_nxt.kick_interval = cfg_data;
        CFG_KICK_SYNC_MIN: cfg_nxt.kick_sync_min = cfg_data[7:0];
        CFG_KICK_MAX_STEPS: cfg_nxt.kick_max_steps = cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reverse_dir    <= 1'b0;
      cfg_r.sector_offset  <= 3'd3;
      cfg_r.kick_duty      <= 5'd6;
      cfg_r.run_duty       <= 5'd7;
      cfg_r.pwm_period     <= 16'd2399;
      cfg_r.kick_interval  <= 16'd600;
      cfg_r.kick_sync_min  <= 8'd2;
      cfg_r.kick_max_steps <= 8'd40;
      settle_r             <= CFG_SETTLE;
      in_vld_r             <= 1'b0;
      out_vld_r            <= 1'b0;
    end else begin
      cfg_r    <= cfg_nxt;
      settle_r <= settle_nxt;
      if (in_valid && in_ready) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  hssc_pulse u_pulse (
    .clk        (clk),
    .cfg        (cfg_r),
    .kick_pulse (kick_pulse),
    .run_pulse  (run_pulse)
  );

  hssc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (advance),
    .item       (in_r),
    .cfg        (cfg_r),
    .kick_pulse (kick_pulse),
    .run_pulse  (run_pulse),
    .res        (res)
  );

  a_kick_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (!out_r.kicking || out_r.running))
    else $error("kicking reported while not running");

  a_settle_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input taken while compare pipeline settles");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_r.step_index <= 3'd5)
    else $error("step index outside the sequence");

  a_stop_turns_off: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_r.func == FUNC_STOP) |=>
      (out_r.mode_u == MODE_OFF && out_r.mode_v == MODE_OFF && out_r.mode_w == MODE_OFF &&
       out_r.compare_u == 17'd0 && !out_r.running))
    else $error("stop left a phase driven");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |-> !advance)
    else $error("result overwritten while stalled");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import hssc_pkg::*;

  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam int unsigned LONG_HOLD   = 150;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned MAX_PRINTS  = 40;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  hall_six_step_commutator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // commutation orders and forward drive patterns per hall code
  logic [2:0] fwd_order [6] = '{3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1};
  logic [2:0] rev_order [6] = '{3'd5, 3'd1, 3'd3, 3'd2, 3'd6, 3'd4};
  phase_mode_t drive_pattern [8][3] = '{
    '{MODE_OFF, MODE_OFF, MODE_OFF}, '{MODE_PWM, MODE_OFF, MODE_LOW},
    '{MODE_LOW, MODE_PWM, MODE_OFF}, '{MODE_OFF, MODE_PWM, MODE_LOW},
    '{MODE_OFF, MODE_LOW, MODE_PWM}, '{MODE_PWM, MODE_LOW, MODE_OFF},
    '{MODE_LOW, MODE_OFF, MODE_PWM}, '{MODE_OFF, MODE_OFF, MODE_OFF}
  };

  // register copies
  logic        set_rev       = 1'b0;
  logic [2:0]  set_offset    = 3'd3;
  logic [4:0]  set_kick_duty = 5'd6;
  logic [4:0]  set_run_duty  = 5'd7;
  logic [15:0] set_period    = 16'd2399;
  logic [15:0] set_interval  = 16'd600;
  logic [7:0]  set_sync_min  = 8'd2;
  logic [7:0]  set_max_steps = 8'd40;

  // commutator state
  logic        m_running    = 1'b0;
  logic        m_kicking    = 1'b0;
  logic        m_fault      = 1'b0;
  logic [2:0]  m_prev_hall  = '0;
  logic [2:0]  m_kick_pos   = '0;
  logic [15:0] m_kick_div   = '0;
  logic [7:0]  m_kick_steps = '0;
  logic [7:0]  m_kick_edges = '0;
  logic [14:0] m_age        = '0;
  logic [15:0] m_edges      = '0;
  logic [4:0]  m_duty       = 5'd6;
  phase_mode_t m_modes [3]  = '{MODE_OFF, MODE_OFF, MODE_OFF};
  logic [16:0] m_cmp [3]    = '{17'd0, 17'd0, 17'd0};
  logic [2:0]  m_last_step  = '0;

  in_item_t    beats_pending [$];
  out_item_t   status_due [$];

  int unsigned queued_beats  = 0;
  int unsigned beats_taken   = 0;
  int unsigned results_seen  = 0;
  int unsigned regs_written  = 0;
  int unsigned mismatches    = 0;
  int unsigned kick_ends     = 0;
  int unsigned invalid_hits  = 0;
  int unsigned src_gap_left  = 0;
  int unsigned sink_gap_left = 0;
  int unsigned sink_hold_left = 0;
  int unsigned sink_holds    = 0;
  int unsigned idle_cycles   = 0;
  bit          in_idle_en    = 1'b0;
  bit          out_idle_en   = 1'b0;
  int          walk_pos      = 0;

  function automatic logic [2:0] order_code(input logic [2:0] pos);
    return set_rev ? rev_order[pos] : fwd_order[pos];
  endfunction

  function automatic logic [2:0] order_pos(input logic [2:0] code);
    for (int i = 0; i < 6; i++) begin
      if (order_code(3'(i)) == code) return 3'(i);
    end
    return 3'd0;
  endfunction

  function automatic logic [2:0] rotate_hall(input logic [2:0] raw);
    int p;
    if (raw == 3'd0 || raw == 3'd7) return raw;
    p = (int'(order_pos(raw)) + int'(set_offset)) % 6;
    return order_code(3'(p));
  endfunction

  function automatic void apply_drive(input logic [2:0] code);
    int unsigned pulse;
    phase_mode_t mode;
    if (code == 3'd0 || code == 3'd7) begin
      // keep the drive, flag it
      m_fault = 1'b1;
      invalid_hits++;
      return;
    end
    pulse = (32'(set_period) * 32'(m_duty)) / 100;
    if (pulse > 32'(set_period)) pulse = 32'(set_period);
    for (int p = 0; p < 3; p++) begin
      mode = drive_pattern[code][p];
      if (set_rev && mode == MODE_PWM) mode = MODE_LOW;
      else if (set_rev && mode == MODE_LOW) mode = MODE_PWM;
      m_modes[p] = mode;
      case (mode)
        MODE_PWM: m_cmp[p] = 17'(pulse);
        MODE_LOW: m_cmp[p] = {1'b0, set_period} + 17'd1;
        default:  m_cmp[p] = 17'd0;
      endcase
    end
    m_fault = 1'b0;
    m_last_step = order_pos(code);
  endfunction

  function automatic void forced_step();
    m_kick_pos = (m_kick_pos >= 3'd5) ? 3'd0 : m_kick_pos + 3'd1;
    if (m_kick_steps != 8'hFF) m_kick_steps++;
    apply_drive(rotate_hall(order_code(m_kick_pos)));
    if (m_kick_edges >= set_sync_min || m_kick_steps >= set_max_steps) begin
      m_kicking = 1'b0;
      m_duty = set_run_duty;
      kick_ends++;
    end
  endfunction

  function automatic void control_tick(input logic [2:0] hall);
    logic edge_seen;
    edge_seen = 1'b0;
    if (!m_running) return;
    if (hall != m_prev_hall) begin
      m_edges = m_edges + 16'd1;
      if (m_kicking && m_kick_edges != 8'hFF) m_kick_edges++;
      m_prev_hall = hall;
      m_age = '0;
      edge_seen = 1'b1;
    end else if (m_age != AGE_MAX) begin
      m_age = m_age + 15'd1;
    end
    if (m_kicking) begin
      m_kick_div = m_kick_div + 16'd1;
      if (m_kick_div >= set_interval) begin
        m_kick_div = '0;
        forced_step();
      end
    end else if (edge_seen) begin
      apply_drive(rotate_hall(hall));
    end
  endfunction

  function automatic void commutator_step(input in_item_t beat);
    out_item_t r;
    case (beat.func)
      FUNC_START: begin
        m_running    = 1'b1;
        m_fault      = 1'b0;
        m_edges      = '0;
        m_kicking    = 1'b1;
        m_duty       = set_kick_duty;
        m_kick_pos   = order_pos(beat.hall_code);
        m_kick_div   = '0;
        m_kick_steps = '0;
        m_kick_edges = '0;
        m_prev_hall  = beat.hall_code;
        apply_drive(rotate_hall(beat.hall_code));
      end
      FUNC_STOP: begin
        m_running = 1'b0;
        m_kicking = 1'b0;
        for (int p = 0; p < 3; p++) begin
          m_modes[p] = MODE_OFF;
          m_cmp[p] = 17'd0;
        end
      end
      FUNC_TICK: control_tick(beat.hall_code);
      default: ;
    endcase
    r.running    = m_running;
    r.kicking    = m_kicking;
    r.fault      = m_fault;
    r.step_index = m_last_step;
    r.mode_u     = m_modes[0];
    r.mode_v     = m_modes[1];
    r.mode_w     = m_modes[2];
    r.compare_u  = m_cmp[0];
    r.compare_v  = m_cmp[1];
    r.compare_w  = m_cmp[2];
    r.edge_age   = m_age;
    r.edge_total = m_edges;
    status_due.push_back(r);
  endfunction

  function automatic void apply_setting(input logic [2:0] idx, input logic [15:0] val);
    logic [4:0] d;
    d = val[4:0];
    case (idx)
      CFG_REVERSE_DIR:    set_rev = val[0];
      CFG_SECTOR_OFFSET:  set_offset = val[2:0] % 3'd6;
      CFG_KICK_DUTY: begin
        set_kick_duty = (d > DUTY_MAX) ? DUTY_MAX : d;
        if (m_kicking) m_duty = set_kick_duty;
      end
      CFG_RUN_DUTY: begin
        set_run_duty = (d > DUTY_MAX) ? DUTY_MAX : d;
        if (!m_kicking) m_duty = set_run_duty;
      end
      CFG_PWM_PERIOD:     set_period = val;
      CFG_KICK_INTERVAL:  set_interval = val;
      CFG_KICK_SYNC_MIN:  set_sync_min = val[7:0];
      CFG_KICK_MAX_STEPS: set_max_steps = val[7:0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic cmp_field(input string name, input logic [16:0] got, input logic [16:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                results_seen, name, got, want));
  endtask

  task automatic check_status(input out_item_t got);
    out_item_t want;
    if (status_due.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      return;
    end
    want = status_due.pop_front();
    cmp_field("running",    17'(got.running),    17'(want.running));
    cmp_field("kicking",    17'(got.kicking),    17'(want.kicking));
    cmp_field("fault",      17'(got.fault),      17'(want.fault));
    cmp_field("step_index", 17'(got.step_index), 17'(want.step_index));
    cmp_field("mode_u",     17'(got.mode_u),     17'(want.mode_u));
    cmp_field("mode_v",     17'(got.mode_v),     17'(want.mode_v));
    cmp_field("mode_w",     17'(got.mode_w),     17'(want.mode_w));
    cmp_field("compare_u",  got.compare_u,       want.compare_u);
    cmp_field("compare_v",  got.compare_v,       want.compare_v);
    cmp_field("compare_w",  got.compare_w,       want.compare_w);
    cmp_field("edge_age",   17'(got.edge_age),   17'(want.edge_age));
    cmp_field("edge_total", 17'(got.edge_total), 17'(want.edge_total));
  endtask

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_length();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // source side: present one beat at a time, random gaps between beats
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        commutator_step(in_data);
        beats_taken++;
      end
      if (!in_valid || in_ready) begin
        if (src_gap_left > 0) begin
          src_gap_left--;
          in_valid <= 1'b0;
        end else if (beats_pending.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= beats_pending.pop_front();
          if (in_idle_en && $urandom_range(0, 99) < 30) src_gap_left = idle_length();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // sink side: check each result beat, stall at random, hold off now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_status(out_data);
        results_seen++;
      end
      if (sink_hold_left == 0 && sink_holds < 3 && results_seen >= (sink_holds + 1) * 300 &&
          beats_pending.size() > 30) begin
        sink_hold_left = LONG_HOLD;
        sink_holds++;
      end
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        out_ready <= 1'b0;
      end else if (sink_gap_left > 0) begin
        sink_gap_left--;
        out_ready <= 1'b0;
      end else if (out_idle_en && $urandom_range(0, 99) < 25) begin
        sink_gap_left = idle_length() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles, %0d results outstanding",
                 $realtime, STALL_LIMIT, status_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic queue_item(input logic [1:0] f, input logic [2:0] h);
    in_item_t b;
    b.func = f;
    b.hall_code = h;
    beats_pending.push_back(b);
    queued_beats++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (beats_taken != queued_beats || status_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_setting(idx, val);
    regs_written++;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // a start, then a hall walk along the active order with some noise mixed in
  task automatic queue_motor_run(input int unsigned n, input int unsigned hold_max,
                                 input int unsigned noise_pct);
    int unsigned r, s, hold;
    bit run_off;
    hold = 0;
    run_off = 1'b0;
    queue_item(FUNC_START, order_code(3'(walk_pos)));
    for (int unsigned i = 1; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (run_off && $urandom_range(0, 9) < 3) begin
        queue_item(FUNC_START, $urandom_range(0, 9) == 0 ? 3'($urandom_range(0, 7))
                                                         : order_code(3'(walk_pos)));
        run_off = 1'b0;
      end else if (r < noise_pct) begin
        s = $urandom_range(0, 9);
        if (s < 2) begin
          queue_item(FUNC_STOP, 3'($urandom_range(0, 7)));
          run_off = 1'b1;
        end else if (s < 4) begin
          queue_item(FUNC_START, order_code(3'(walk_pos)));
        end else if (s < 5) begin
          queue_item(FUNC_UNUSED, 3'($urandom_range(0, 7)));
        end else begin
          queue_item(FUNC_TICK, 3'($urandom_range(0, 7)));
        end
      end else begin
        if (hold == 0) begin
          walk_pos = ($urandom_range(0, 9) == 0) ? (walk_pos + 5) % 6 : (walk_pos + 1) % 6;
          hold = $urandom_range(0, hold_max);
        end else begin
          hold--;
        end
        queue_item(FUNC_TICK, order_code(3'(walk_pos)));
      end
    end
  endtask

  task automatic write_all(input logic rev, input logic [2:0] ofs, input logic [4:0] kd,
                           input logic [4:0] rd, input logic [15:0] per,
                           input logic [15:0] ivl, input logic [7:0] smin,
                           input logic [7:0] smax);
    write_reg(CFG_REVERSE_DIR, 16'(rev));
    write_reg(CFG_SECTOR_OFFSET, 16'(ofs));
    write_reg(CFG_KICK_DUTY, 16'(kd));
    write_reg(CFG_RUN_DUTY, 16'(rd));
    write_reg(CFG_PWM_PERIOD, per);
    write_reg(CFG_KICK_INTERVAL, ivl);
    write_reg(CFG_KICK_SYNC_MIN, 16'(smin));
    write_reg(CFG_KICK_MAX_STEPS, 16'(smax));
  endtask

  function automatic logic [4:0] pick_duty();
    return ($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31)) : 5'($urandom_range(0, 25));
  endfunction

  initial begin
    int unsigned r_per, r_ivl, r_lim;
    logic [15:0] per, ivl;
    logic [7:0]  smin, smax;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: stopped ticks, invalid halls, restart, stop
    queue_item(FUNC_TICK, 3'd3);
    queue_item(FUNC_UNUSED, 3'd6);
    queue_item(FUNC_STOP, 3'd1);
    queue_item(FUNC_START, 3'd0);
    queue_item(FUNC_TICK, 3'd0);
    queue_item(FUNC_TICK, 3'd7);
    queue_item(FUNC_START, 3'd7);
    queue_item(FUNC_START, 3'd5);
    queue_item(FUNC_TICK, 3'd5);
    queue_item(FUNC_TICK, 3'd4);
    queue_item(FUNC_TICK, 3'd6);
    queue_item(FUNC_UNUSED, 3'd2);
    queue_item(FUNC_STOP, 3'd2);
    queue_item(FUNC_TICK, 3'd2);
    queue_item(FUNC_START, 3'd1);
    wait_drained();

    // zero interval and zero limits: the kick ends on the first tick
    write_reg(CFG_KICK_INTERVAL, 16'd0);
    write_reg(CFG_KICK_SYNC_MIN, 16'd0);
    write_reg(CFG_KICK_MAX_STEPS, 16'd0);
    queue_item(FUNC_START, 3'd3);
    queue_item(FUNC_TICK, 3'd3);
    queue_item(FUNC_TICK, 3'd2);
    queue_item(FUNC_TICK, 3'd7);
    queue_item(FUNC_TICK, 3'd0);
    queue_item(FUNC_TICK, 3'd5);
    queue_item(FUNC_STOP, 3'd4);
    wait_drained();

    for (int ph = 0; ph < 11; ph++) begin
      case (ph)
        // long kick that ends on edge count, rapid halls
        0: write_all(1'b1, 3'd5, 5'd25, 5'd0, 16'hFFFF, 16'd3, 8'd255, 8'd255);
        1: write_all(1'b0, 3'd0, 5'd0, 5'd25, 16'd1, 16'hFFFF, 8'd1, 8'd1);
        // duty writes above the cap
        2: write_all(1'b0, 3'd2, 5'd31, 5'd30, 16'hFFFF, 16'd2, 8'd1, 8'd255);
        default: begin
          r_per = $urandom_range(0, 99);
          r_ivl = $urandom_range(0, 99);
          r_lim = $urandom_range(0, 99);
          per  = (r_per < 20) ? 16'($urandom_range(1, 16)) :
                 (r_per < 35) ? 16'hFFFF : 16'($urandom_range(1, 65535));
          ivl  = (r_ivl < 60) ? 16'($urandom_range(1, 6)) :
                 (r_ivl < 92) ? 16'($urandom_range(7, 40)) : 16'd0;
          smin = (r_lim < 85) ? 8'($urandom_range(0, 4)) : 8'd255;
          smax = (r_lim < 70) ? 8'($urandom_range(1, 12)) :
                 (r_lim < 90) ? 8'd255 : 8'd0;
          write_all(1'($urandom_range(0, 1)), 3'($urandom_range(0, 5)), pick_duty(),
                    pick_duty(), per, ivl, smin, smax);
        end
      endcase
      in_idle_en  = (ph % 4) != 3;
      out_idle_en = (ph % 3) != 2;
      if (ph == 0) queue_motor_run(300, 0, 0);
      else queue_motor_run(100, $urandom_range(0, 4), 10);
      wait_drained();
    end

    $display("Checked %0d input beats against %0d result beats, with %0d register writes.",
             beats_taken, results_seen, regs_written);
    $display("Open-loop kicks ended %0d times; %0d commutations hit an invalid hall code.",
             kick_ends, invalid_hits);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/hssc_pkg.sv
hdl/hssc_pulse.sv
hdl/hssc_core.sv
hdl/hall_six_step_commutator.sv
dv/testbench.sv
